/* src/jk64_pkg.sv */
// jk64_pkg: constants, types and command struct for the jkiss64 generator
// shared by jk64_ctrl, jk64_datapath and the top level; no dependencies
`default_nettype none
package jk64_pkg;

  localparam int WARMUP_STEPS = 100;
  localparam int CNT_W = $clog2(WARMUP_STEPS + 8);

  localparam logic [63:0] LCG64_MUL = 64'd1490024343005336237;
  localparam logic [63:0] LCG64_ADD = 64'd123456789;
  localparam logic [31:0] MWC_MUL_A = 32'd4294584393;
  localparam logic [31:0] MWC_MUL_B = 32'd4246477509;
  localparam logic [31:0] LCG32_MUL = 32'd314527869;
  localparam logic [31:0] LCG32_ADD = 32'd1234567;
  localparam int XS64_SHL_A = 21;
  localparam int XS64_SHR = 17;
  localparam int XS64_SHL_B = 30;
  localparam int XS32_SHL_A = 5;
  localparam int XS32_SHR = 7;
  localparam int XS32_SHL_B = 22;
  localparam int SEED_SHR = 11;

  localparam logic [63:0] RST_LCG = 64'd123456789123;
  localparam logic [63:0] RST_XS = 64'd987654321987;
  localparam logic [31:0] RST_MWC_V = 32'd43219876;
  localparam logic [31:0] RST_MWC_C = 32'd6543217;
  localparam logic [31:0] RST_MWC2_V = 32'd21987643;
  localparam logic [31:0] RST_MWC2_C = 32'd1732654;
  localparam logic [31:0] RST_S_LCG = 32'd123456789;
  localparam logic [31:0] RST_S_XS = 32'd987654321;
  localparam logic [31:0] RST_S_MWC_V = 32'd43219876;
  localparam logic [31:0] RST_S_MWC_C = 32'd6543217;

  localparam logic [1:0] OP_DRAW32 = 2'd0;
  localparam logic [1:0] OP_DRAW64 = 2'd1;
  localparam logic [1:0] OP_RESEED = 2'd2;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LCG_LL,
    MUL_LCG_LH,
    MUL_LCG_HL,
    MUL_MWC1,
    MUL_MWC2,
    MUL_SLCG,
    MUL_SMWC,
    MUL_SQ,
    MUL_CUBE
  } mul_sel_t;

  typedef enum logic [2:0] {
    FILL_LCG_HI,
    FILL_XS_HI,
    FILL_MWC_V,
    FILL_MWC_C,
    FILL_MWC2_V,
    FILL_MWC2_C,
    FILL_LCG_LO,
    FILL_XS_LO
  } fill_sel_t;

  typedef struct packed {
    mul_sel_t  mul_sel;
    logic      xs_step;
    logic      sxs_step;
    logic      load_seed;
    logic      fill;
    fill_sel_t fill_sel;
    logic      out_load;
    logic      wide;
  } cmd_t;

endpackage
`default_nettype wire

/* src/jkiss64_generator_with_reseed_core.sv */
// jkiss64_generator_with_reseed_core: top level of the kiss-style generator
// depends on jk64_pkg, jk64_ctrl and jk64_datapath
//
// input channel: in_valid/in_ready with opcode and seed_value. opcode 0 draws a
// 32-bit value, 1 draws a 64-bit value, 2 reseeds from seed_value, 3 is a no-op.
// output channel: out_valid/out_ready with random_value, one item per draw,
// none for reseed or no-op.
// a draw is sequenced on one shared 32x32 multiplier (three partial products
// for the 64-bit lcg, then the mwc pairs); the next item is accepted in the
// cycle after the result is loaded.
// a reseed runs 108 seeder steps on the same multiplier, producing no output item.
// a finished result waits in the output register; a new item may be accepted
// meanwhile, and a following draw holds in its last cycle until the register
// is free. reset loads the fixed default generator state and clears out_valid.
`default_nettype none
module jkiss64_generator_with_reseed_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      random_value
);

  jk64_pkg::cmd_t cmd;

  jk64_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  jk64_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .random_value (random_value)
  );

endmodule
`default_nettype wire

/* src/jk64_datapath.sv */
// jk64_datapath: generator state, shared 32x32 multiplier and output register
// depends on jk64_pkg; driven by jk64_ctrl commands
`default_nettype none
module jk64_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jk64_pkg::cmd_t cmd,
  input  wire logic [31:0]   seed_value,
  output logic [63:0]        random_value
);

  logic [63:0] lcg, xs, acc, prod;
  logic [31:0] mwc_v, mwc_c, mwc2_v, mwc2_c;
  logic [31:0] s_lcg, s_xs, s_mwc_v, s_mwc_c, seed_reg;
  jk64_pkg::mul_sel_t wb_sel;
  logic [31:0] op_a, op_b;
  logic [63:0] xs1, xs2, xs3;
  logic [31:0] sx1, sx2, sx3, s_out, out32;
  logic [63:0] out64;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      jk64_pkg::MUL_LCG_LL: begin op_a = lcg[31:0];  op_b = jk64_pkg::LCG64_MUL[31:0];  end
      jk64_pkg::MUL_LCG_LH: begin op_a = lcg[31:0];  op_b = jk64_pkg::LCG64_MUL[63:32]; end
      jk64_pkg::MUL_LCG_HL: begin op_a = lcg[63:32]; op_b = jk64_pkg::LCG64_MUL[31:0];  end
      jk64_pkg::MUL_MWC1:   begin op_a = mwc_v;      op_b = jk64_pkg::MWC_MUL_A;        end
      jk64_pkg::MUL_MWC2:   begin op_a = mwc2_v;     op_b = jk64_pkg::MWC_MUL_B;        end
      jk64_pkg::MUL_SLCG:   begin op_a = s_lcg;      op_b = jk64_pkg::LCG32_MUL;        end
      jk64_pkg::MUL_SMWC:   begin op_a = s_mwc_v;    op_b = jk64_pkg::MWC_MUL_A;        end
      jk64_pkg::MUL_SQ:     begin op_a = seed_reg;   op_b = seed_reg;                   end
      jk64_pkg::MUL_CUBE:   begin op_a = prod[31:0]; op_b = seed_reg;                   end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    xs1 = xs ^ (xs << jk64_pkg::XS64_SHL_A);
    xs2 = xs1 ^ (xs1 >> jk64_pkg::XS64_SHR);
    xs3 = xs2 ^ (xs2 << jk64_pkg::XS64_SHL_B);
    sx1 = s_xs ^ (s_xs << jk64_pkg::XS32_SHL_A);
    sx2 = sx1 ^ (sx1 >> jk64_pkg::XS32_SHR);
    sx3 = sx2 ^ (sx2 << jk64_pkg::XS32_SHL_B);
    s_out = s_lcg + s_xs + s_mwc_v;
    out32 = lcg[63:32] + xs[31:0] + mwc_v;
    out64 = lcg + xs + {32'd0, mwc_v} + {mwc2_v, 32'd0};
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, op_a} * {32'd0, op_b};
    if (cmd.out_load) begin
      random_value <= cmd.wide ? out64 : {32'd0, out32};
    end
    if (cmd.load_seed) begin
      seed_reg <= seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_sel  <= jk64_pkg::MUL_NONE;
      lcg     <= jk64_pkg::RST_LCG;
      xs      <= jk64_pkg::RST_XS;
      mwc_v   <= jk64_pkg::RST_MWC_V;
      mwc_c   <= jk64_pkg::RST_MWC_C;
      mwc2_v  <= jk64_pkg::RST_MWC2_V;
      mwc2_c  <= jk64_pkg::RST_MWC2_C;
      s_lcg   <= jk64_pkg::RST_S_LCG;
      s_xs    <= jk64_pkg::RST_S_XS;
      s_mwc_v <= jk64_pkg::RST_S_MWC_V;
      s_mwc_c <= jk64_pkg::RST_S_MWC_C;
      acc     <= '0;
    end else begin
      wb_sel <= cmd.mul_sel;
      case (wb_sel)
        jk64_pkg::MUL_LCG_LL: acc <= prod + jk64_pkg::LCG64_ADD;
        jk64_pkg::MUL_LCG_LH: acc[63:32] <= acc[63:32] + prod[31:0];
        jk64_pkg::MUL_LCG_HL: lcg <= {acc[63:32] + prod[31:0], acc[31:0]};
        jk64_pkg::MUL_MWC1:   {mwc_c, mwc_v} <= prod + {32'd0, mwc_c};
        jk64_pkg::MUL_MWC2:   {mwc2_c, mwc2_v} <= prod + {32'd0, mwc2_c};
        jk64_pkg::MUL_SLCG:   s_lcg <= prod[31:0] + jk64_pkg::LCG32_ADD;
        jk64_pkg::MUL_SMWC:   {s_mwc_c, s_mwc_v} <= prod + {32'd0, s_mwc_c};
        jk64_pkg::MUL_SQ:     s_xs <= prod[31:0];
        jk64_pkg::MUL_CUBE:   s_mwc_v <= prod[31:0];
        default: ;
      endcase
      if (cmd.xs_step) begin
        xs <= xs3;
      end
      if (cmd.sxs_step) begin
        s_xs <= sx3;
      end
      if (cmd.load_seed) begin
        s_lcg   <= seed_value;
        s_mwc_c <= seed_value ^ (seed_value >> jk64_pkg::SEED_SHR);
      end
      if (cmd.fill) begin
        case (cmd.fill_sel)
          jk64_pkg::FILL_LCG_HI: lcg[63:32] <= s_out;
          jk64_pkg::FILL_XS_HI:  xs[63:32] <= s_out;
          jk64_pkg::FILL_MWC_V:  mwc_v <= s_out;
          jk64_pkg::FILL_MWC_C:  mwc_c <= s_out;
          jk64_pkg::FILL_MWC2_V: mwc2_v <= s_out;
          jk64_pkg::FILL_MWC2_C: mwc2_c <= s_out;
          jk64_pkg::FILL_LCG_LO: lcg[31:0] <= s_out;
          jk64_pkg::FILL_XS_LO:  xs[31:0] <= s_out;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* src/jk64_ctrl.sv */
// jk64_ctrl: sequencer for draws and reseeds, handshakes and output valid
// depends on jk64_pkg; commands jk64_datapath
`default_nettype none
module jk64_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     opcode,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jk64_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DRAW = 6'b000010,
    S_SQ   = 6'b000100,
    S_CUBE = 6'b001000,
    S_STEP = 6'b010000,
    S_FILL = 6'b100000
  } state_t;

  localparam logic [jk64_pkg::CNT_W-1:0] CNT_LAST =
    jk64_pkg::CNT_W'(jk64_pkg::WARMUP_STEPS + 7);
  localparam logic [jk64_pkg::CNT_W-1:0] CNT_FIRST_FILL =
    jk64_pkg::CNT_W'(jk64_pkg::WARMUP_STEPS + 1);
  localparam logic [jk64_pkg::CNT_W-1:0] CNT_END =
    jk64_pkg::CNT_W'(jk64_pkg::WARMUP_STEPS + 8);

  state_t state, state_next;
  logic [2:0] phase, phase_next;
  logic [jk64_pkg::CNT_W-1:0] cnt, cnt_next, fill_off;
  logic wide, wide_next, out_valid_next;

  assign fill_off = cnt - CNT_FIRST_FILL;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next = cnt;
    wide_next = wide;
    in_ready = 1'b0;
    cmd = '0;
    cmd.mul_sel = jk64_pkg::MUL_NONE;
    cmd.fill_sel = jk64_pkg::FILL_LCG_HI;
    cmd.wide = wide;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        phase_next = '0;
        cnt_next = '0;
        if (in_valid) begin
          case (opcode)
            jk64_pkg::OP_DRAW32: begin
              state_next = S_DRAW;
              wide_next = 1'b0;
            end
            jk64_pkg::OP_DRAW64: begin
              state_next = S_DRAW;
              wide_next = 1'b1;
            end
            jk64_pkg::OP_RESEED: begin
              cmd.load_seed = 1'b1;
              state_next = S_SQ;
            end
            default: ;
          endcase
        end
      end
      S_DRAW: begin
        phase_next = phase + 3'd1;
        case (phase)
          3'd0: begin
            cmd.mul_sel = jk64_pkg::MUL_LCG_LL;
            cmd.xs_step = 1'b1;
          end
          3'd1: cmd.mul_sel = jk64_pkg::MUL_LCG_LH;
          3'd2: cmd.mul_sel = jk64_pkg::MUL_LCG_HL;
          3'd3: cmd.mul_sel = jk64_pkg::MUL_MWC1;
          3'd4: cmd.mul_sel = wide ? jk64_pkg::MUL_MWC2 : jk64_pkg::MUL_NONE;
          3'd5: ;
          default: begin
            phase_next = phase;
            if (!out_valid || out_ready) begin
              cmd.out_load = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_SQ: begin
        cmd.mul_sel = jk64_pkg::MUL_SQ;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.mul_sel = jk64_pkg::MUL_CUBE;
        state_next = S_STEP;
        phase_next = '0;
        cnt_next = '0;
      end
      S_STEP: begin
        phase_next = phase + 3'd1;
        case (phase)
          3'd0: begin
            cmd.mul_sel = jk64_pkg::MUL_SLCG;
            if (cnt >= CNT_FIRST_FILL) begin
              cmd.fill = 1'b1;
              cmd.fill_sel = jk64_pkg::fill_sel_t'(fill_off[2:0]);
            end
          end
          3'd1: cmd.mul_sel = jk64_pkg::MUL_SMWC;
          default: begin
            cmd.sxs_step = 1'b1;
            phase_next = '0;
            cnt_next = cnt + 1'b1;
            if (cnt == CNT_LAST) begin
              state_next = S_FILL;
            end
          end
        endcase
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        cmd.fill_sel = jk64_pkg::FILL_XS_LO;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
      cnt <= '0;
      wide <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt <= cnt_next;
      wide <= wide_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output overwritten while stalled");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_END)
    else $error("warmup counter out of range");
  a_fill_reseed: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> (state == S_STEP || state == S_FILL))
    else $error("fill outside reseed");
  a_load_after_draw: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench for jkiss64_generator_with_reseed_core: draws, reseeds and no-ops
// checked against a behavioral copy of the generator; depends on jk64_pkg
`timescale 1ns / 1ps
`default_nettype none

class draw_scoreboard;
  logic [63:0] lcg, xs;
  logic [31:0] mv, mc, m2v, m2c, s_lcg, s_xs, s_mv, s_mc;
  logic [63:0] pending[$];
  int errors = 0;
  int draws = 0;
  int reseeds = 0;

  function new();
    lcg = jk64_pkg::RST_LCG; xs = jk64_pkg::RST_XS;
    mv = jk64_pkg::RST_MWC_V; mc = jk64_pkg::RST_MWC_C;
    m2v = jk64_pkg::RST_MWC2_V; m2c = jk64_pkg::RST_MWC2_C;
    s_lcg = jk64_pkg::RST_S_LCG; s_xs = jk64_pkg::RST_S_XS;
    s_mv = jk64_pkg::RST_S_MWC_V; s_mc = jk64_pkg::RST_S_MWC_C;
  endfunction

  function logic [31:0] seeder_out();
    logic [63:0] t;
    logic [31:0] v;
    s_lcg = 32'd314527869 * s_lcg + 32'd1234567;
    v = s_xs;
    v ^= v << 5;
    v ^= v >> 7;
    v ^= v << 22;
    s_xs = v;
    t = 64'd4294584393 * {32'd0, s_mv} + {32'd0, s_mc};
    s_mc = t[63:32];
    s_mv = t[31:0];
    return s_lcg + s_xs + s_mv;
  endfunction

  function void advance();
    logic [63:0] t;
    lcg = 64'd1490024343005336237 * lcg + 64'd123456789;
    xs ^= xs << 21;
    xs ^= xs >> 17;
    xs ^= xs << 30;
    t = 64'd4294584393 * {32'd0, mv} + {32'd0, mc};
    mc = t[63:32];
    mv = t[31:0];
  endfunction

  function void note_input(logic [1:0] op, logic [31:0] seed);
    logic [63:0] t;
    logic [31:0] o1, o2, o7, o8, sq, r;
    if (op == jk64_pkg::OP_DRAW32) begin
      advance();
      r = lcg[63:32] + xs[31:0] + mv;
      pending.push_back({32'd0, r});
      draws++;
    end else if (op == jk64_pkg::OP_DRAW64) begin
      advance();
      t = 64'd4246477509 * {32'd0, m2v} + {32'd0, m2c};
      m2c = t[63:32];
      m2v = t[31:0];
      pending.push_back(lcg + xs + {32'd0, mv} + {m2v, 32'd0});
      draws++;
    end else if (op == jk64_pkg::OP_RESEED) begin
      sq = seed * seed;
      s_lcg = seed; s_xs = sq; s_mv = sq * seed; s_mc = seed ^ (seed >> 11);
      for (int i = 0; i < jk64_pkg::WARMUP_STEPS; i++) void'(seeder_out());
      o1 = seeder_out(); o2 = seeder_out();
      mv = seeder_out(); mc = seeder_out();
      m2v = seeder_out(); m2c = seeder_out();
      o7 = seeder_out(); o8 = seeder_out();
      lcg = {o1, o7};
      xs = {o2, o8};
      reseeds++;
    end
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    if (pending.size() == 0) begin
      $error("random_value: no item expected, actual %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $error("random_value: expected %h actual %h", want, got);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [31:0] seed_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] random_value;
  logic sending_done = 1'b0;
  logic hold_off = 1'b0;
  int accepted = 0;
  draw_scoreboard sb = new();

  jkiss64_generator_with_reseed_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .seed_value(seed_value), .out_valid(out_valid),
    .out_ready(out_ready), .random_value(random_value)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_input(opcode, seed_value);
      accepted++;
    end
    if (!rst && out_valid && out_ready) sb.check_result(random_value);
  end

  task automatic send_item(logic [1:0] op, logic [31:0] seed, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    seed_value <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off while items keep coming
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off <= 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [1:0] op;
    logic [31:0] sd;
    int gap;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_item(jk64_pkg::OP_DRAW32, 32'h0, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'hffffffff, 0);
    send_item(2'd3, 32'h12345678, 1);
    send_item(jk64_pkg::OP_DRAW32, 32'h0, 0);
    send_item(jk64_pkg::OP_RESEED, 32'h0, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'h0, 0);
    send_item(jk64_pkg::OP_DRAW32, 32'h0, 2);
    send_item(jk64_pkg::OP_RESEED, 32'hffffffff, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'haaaaaaaa, 0);
    send_item(jk64_pkg::OP_RESEED, 32'h1, 3);
    send_item(jk64_pkg::OP_DRAW32, 32'h55555555, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'h0, 0);
    send_item(jk64_pkg::OP_RESEED, 32'h800, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'h0, 0);
    send_item(2'd3, 32'hffffffff, 0);
    send_item(jk64_pkg::OP_DRAW64, 32'h0, 0);
    hold_off <= 1'b1;
    for (int i = 0; i < 950; i++) begin
      case ($urandom_range(0, 19))
        0, 1: op = jk64_pkg::OP_RESEED;
        2: op = 2'd3;
        3, 4, 5, 6, 7, 8, 9, 10: op = jk64_pkg::OP_DRAW32;
        default: op = jk64_pkg::OP_DRAW64;
      endcase
      sd = $urandom();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      send_item(op, sd, gap);
    end
    in_valid <= 1'b0;
    sending_done <= 1'b1;
  end

  initial begin
    @(posedge sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d items: %0d draws checked, %0d reseeds", accepted, sb.draws,
             sb.reseeds);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
